@@ design/assert_macros.svh @@
// Assertion macros for the design files; the top level includes them.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check with asynchronous active-low reset masking
`define PPWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds while out of reset
`define PPWC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/ppwc_pkg.sv @@
// Shared types and constants for the pulse period window checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ppwc_pkg;

    // Run counter width
    localparam int CountWidth = 8;
    // Width of bounds, window and tick counter
    localparam int FieldWidth = 8;
    localparam int AddrWidth  = 4;
    localparam int DataWidth  = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_LOWER  = 2'd0;
    localparam logic [1:0] REG_UPPER  = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    // Reset values of the registers
    localparam logic [FieldWidth-1:0] LowerReset  = 8'd33;
    localparam logic [FieldWidth-1:0] UpperReset  = 8'd83;
    localparam logic [FieldWidth-1:0] WindowReset = 8'd10;

    typedef struct packed {
        logic [FieldWidth-1:0] lower;
        logic [FieldWidth-1:0] upper;
        logic [FieldWidth-1:0] window;
    } cfg_t;

    typedef struct packed {
        logic fire;
        logic in_range;
    } verdict_t;

endpackage

@@ design/ppwc_cfg.sv @@
// APB-style configuration registers: bounds and window length.
// Depends on ppwc_pkg.
`timescale 1ns / 1ps

module ppwc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppwc_pkg::AddrWidth-1:0] paddr,
    input  logic [ppwc_pkg::DataWidth-1:0] pwdata,
    output logic [ppwc_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    output ppwc_pkg::cfg_t                cfg
);
    import ppwc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_LOWER:  cfg_next.lower  = pwdata[FieldWidth-1:0];
                REG_UPPER:  cfg_next.upper  = pwdata[FieldWidth-1:0];
                REG_WINDOW: cfg_next.window = pwdata[FieldWidth-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower  <= LowerReset;
            cfg_reg.upper  <= UpperReset;
            cfg_reg.window <= WindowReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_LOWER:  prdata = DataWidth'(cfg_reg.lower);
            REG_UPPER:  prdata = DataWidth'(cfg_reg.upper);
            REG_WINDOW: prdata = DataWidth'(cfg_reg.window);
            default:    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ design/ppwc_track.sv @@
// Run length tracking, tick counter and window verdict.
// Depends on ppwc_pkg.
`timescale 1ns / 1ps

module ppwc_track (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             level,
    input  ppwc_pkg::cfg_t   cfg,
    output ppwc_pkg::verdict_t verdict
);
    import ppwc_pkg::*;

    logic [CountWidth-1:0] high_run_reg,  high_run_next;
    logic [CountWidth-1:0] low_run_reg,   low_run_next;
    logic [CountWidth-1:0] last_high_reg, last_high_next;
    logic [CountWidth-1:0] last_low_reg,  last_low_next;
    logic [FieldWidth-1:0] tick_reg,      tick_next;
    logic [FieldWidth-1:0] tick_inc;
    logic [FieldWidth-1:0] sum;
    logic [CountWidth-1:0] upper_ext;

    assign upper_ext = CountWidth'(cfg.upper);

    // Advance run counters and latch the finished run
    always_comb
    begin
        high_run_next  = high_run_reg;
        low_run_next   = low_run_reg;
        last_high_next = last_high_reg;
        last_low_next  = last_low_reg;
        if (!level)
        begin
            low_run_next = low_run_reg + 1'b1;
            if (high_run_reg != '0)
            begin
                last_high_next = high_run_reg;
                high_run_next  = '0;
            end
        end
        else
        begin
            high_run_next = high_run_reg + 1'b1;
            if (low_run_reg != '0)
            begin
                last_low_next = low_run_reg;
                low_run_next  = '0;
            end
        end
        // Drop overlong runs
        if (low_run_next > upper_ext)
        begin
            low_run_next  = '0;
            last_low_next = '0;
        end
        if (high_run_next > upper_ext)
        begin
            high_run_next  = '0;
            last_high_next = '0;
        end
    end

    // Window count and verdict
    assign tick_inc = tick_reg + 1'b1;
    assign sum      = last_low_next[FieldWidth-1:0] + last_high_next[FieldWidth-1:0];

    always_comb
    begin
        verdict.fire     = (tick_inc >= cfg.window);
        verdict.in_range = (sum >= cfg.lower) && (sum <= cfg.upper);
        tick_next        = verdict.fire ? '0 : tick_inc;
    end

    // Update state on each advancing item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_run_reg  <= '0;
            low_run_reg   <= '0;
            last_high_reg <= '0;
            last_low_reg  <= '0;
            tick_reg      <= '0;
        end
        else if (advance)
        begin
            high_run_reg  <= high_run_next;
            low_run_reg   <= low_run_next;
            last_high_reg <= last_high_next;
            last_low_reg  <= last_low_next;
            tick_reg      <= tick_next;
        end
    end

endmodule

@@ design/pulse_period_window_checker_unit.sv @@
// Top level of the pulse period window checker: input and result registers.
// Depends on ppwc_pkg, ppwc_cfg, ppwc_track and assert_macros.svh.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------
//   in      | in_valid, in_stall | level
//   out     | out_valid, out_stall | in_range
//   config  | APB psel/penable   | paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled; a verdict
// is captured in the result register when its item leaves the input register
// and the window fires. The path is input register, counter update and
// compares, then the result register. Reset restores registers to 33/83/10
// and clears all counters. A stalled result holds the input register; further
// items that yield no verdict still wait behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pulse_period_window_checker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          level,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          in_range,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppwc_pkg::AddrWidth-1:0] paddr,
    input  logic [ppwc_pkg::DataWidth-1:0] pwdata,
    output logic [ppwc_pkg::DataWidth-1:0] prdata,
    output logic                          pready
);
    import ppwc_pkg::*;

    cfg_t     cfg;
    verdict_t verdict;
    logic     s1_valid_reg, s1_valid_next;
    logic     s1_level_reg;
    logic     out_valid_reg, out_valid_next;
    logic     in_range_reg;
    logic     advance;
    logic     in_take;
    logic     fire_take;

    ppwc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppwc_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .level   (s1_level_reg),
        .cfg     (cfg),
        .verdict (verdict)
    );

    // Move the held item on when the result slot is free or draining
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign fire_take = advance && verdict.fire;

    always_comb
    begin
        s1_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        if (fire_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_level_reg <= level;
        end
        if (fire_take)
        begin
            in_range_reg <= verdict.in_range;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_range  = in_range_reg;

    // Checks on the internal pipeline
    `PPWC_ASSERT(a_stall_needs_item, clk, rst_n, in_stall |-> s1_valid_reg, "stall while empty")
    `PPWC_NEVER(a_no_overwrite, clk, rst_n, fire_take && out_valid && out_stall, "verdict lost")
    `PPWC_ASSERT(a_verdict_lands, clk, rst_n, fire_take |=> out_valid, "verdict not registered")

endmodule
